// File: sv/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg: shared types and character tables for the lexeme splitter
// Holds the scan state record, the result record and the delimiter,
// blank and operator classification functions.
// ----------------------------------------------------------------------------
package sls_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER_SET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_CHAR_TOKENS = 2'd1;

    localparam logic [2:0] SET_COMMAND = 3'd0;
    localparam logic [2:0] SET_SUB     = 3'd1;
    localparam logic [2:0] SET_COMMA   = 3'd2;
    localparam logic [2:0] SET_BQ      = 3'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CTRL_Q = 8'h11;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_WORD    = 2'd1,
        MODE_QUOTE   = 2'd2,
        MODE_PAIR    = 2'd3
    } t_scan_mode;

    typedef struct packed {
        t_scan_mode mode;
        logic       quote_dq;   // open quote is a double quote
        logic       ctrl_q;     // previous quoted byte was 0x11
        logic [7:0] pair_byte;  // pending operator first byte
    } t_scan_state;

    typedef struct packed {
        logic       present;
        logic [7:0] out_byte;
        logic       begins;
        logic       eot;
        logic       unmatched;
    } t_result;

    localparam t_scan_state SCAN_RESET = '{
        mode: MODE_BETWEEN, quote_dq: 1'b0, ctrl_q: 1'b0, pair_byte: 8'h00
    };

    // Space, tab, CR and LF.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    function automatic logic is_delim(input logic [2:0] sel, input logic [7:0] c);
        logic r;
        r = 1'b0;
        case (sel)
            SET_COMMAND: r = c inside {8'h3B, 8'h20, 8'h09, 8'h0D, 8'h0A,
                                       8'h60, 8'h27, 8'h22};
            SET_SUB:     r = c inside {8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
                                       8'h26, 8'h2D, 8'h3D, 8'h2B, 8'h60, 8'h7B,
                                       8'h7D, 8'h3A, 8'h3B, 8'h27, 8'h22, 8'h5C,
                                       8'h7C, 8'h2C, 8'h2E, 8'h3C, 8'h3E, 8'h2F};
            SET_COMMA:   r = (c == 8'h2C);
            SET_BQ:      r = c inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h27, 8'h22};
            default:     r = is_blank(c);
        endcase
        return r;
    endfunction

    // First bytes of the two-byte operators: > = < ! / ~
    function automatic logic is_op_lead(input logic [7:0] c);
        return c inside {8'h3E, 8'h3D, 8'h3C, 8'h21, 8'h2F, 8'h7E};
    endfunction

    // Operators >> >= <= == != /= =~ /~
    function automatic logic is_operator(input logic [7:0] a, input logic [7:0] b);
        return {a, b} inside {16'h3E3E, 16'h3E3D, 16'h3C3D, 16'h3D3D,
                              16'h213D, 16'h2F3D, 16'h3D7E, 16'h2F7E};
    endfunction

endpackage

// File: sv/shell_lexeme_splitter_unit.sv
// ----------------------------------------------------------------------------
// shell_lexeme_splitter_unit: splits a byte stream into shell lexemes
// Drops blanks met between lexemes, passes every kept byte with a lexeme-start flag,
// handles quoted lexemes and optional two-byte operators, and closes the
// text with an end item on byte 0.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ---------------------------------------
//  text in   i_in_valid / o_in_ready    i_text_byte
//  result    o_out_valid / i_out_ready  o_out_byte, o_begins_lexeme,
//                                       o_end_of_text, o_unmatched_quote
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An input item is accepted in every cycle while the result side keeps up;
// one item per cycle is the sustained rate. A byte is held in the input
// register, where the scan step decides its result and the next scan
// state; the result is then held in the result register, from which it
// is offered on the result channel.
// Bytes that produce no result (dropped blanks) leave the pipe even while
// the result register is held. Reset is synchronous and active low; it
// clears the scan state, both configuration registers and the valid flags.
// A stalled result holds the input register, and with it the input channel.
//
module shell_lexeme_splitter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_text_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_out_byte,
    output logic                            o_begins_lexeme,
    output logic                            o_end_of_text,
    output logic                            o_unmatched_quote,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sls_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sls_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sls_pkg::*;

    // Configuration registers.
    logic [2:0]  r_delimiter_set;
    logic        r_two_char_tokens;

    // Input register stage.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Scan state carried from byte to byte.
    t_scan_state r_state;
    t_scan_state n_state;
    t_result     w_result;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_begins;
    logic        r_eot;
    logic        r_unmatched;

    logic        w_advance;
    logic        w_in_take;

    sls_lex_core u_core (
        .i_byte            (r_in_byte),
        .i_delimiter_set   (r_delimiter_set),
        .i_two_char_tokens (r_two_char_tokens),
        .i_state           (r_state),
        .o_state           (n_state),
        .o_result          (w_result)
    );

    // The held byte moves on when the result register can take its result,
    // or at once when it has no result to give.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready || !w_result.present);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    // Configuration must only be written while the block is idle; the block itself does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter_set   <= 3'd0;
            r_two_char_tokens <= 1'b0;
            r_in_valid        <= 1'b0;
            r_state           <= SCAN_RESET;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_DELIMITER_SET) begin
                    r_delimiter_set <= i_cfg_data[2:0];
                end else if (i_cfg_index == CFG_TWO_CHAR_TOKENS) begin
                    r_two_char_tokens <= i_cfg_data[0];
                end
            end
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance && w_result.present) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_text_byte;
        end
        if (w_advance && w_result.present) begin
            r_out_byte  <= w_result.out_byte;
            r_begins    <= w_result.begins;
            r_eot       <= w_result.eot;
            r_unmatched <= w_result.unmatched;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_begins_lexeme   = r_begins;
    assign o_end_of_text     = r_eot;
    assign o_unmatched_quote = r_unmatched;

    // The end item carries a zero byte and never starts a lexeme.
    a_eot_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_text) |-> (o_out_byte == 8'h00 && !o_begins_lexeme))
        else $error("end item with nonzero byte or lexeme start");

    // An unmatched quote is only reported on the end item.
    a_unmatched_on_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unmatched_quote) |-> o_end_of_text)
        else $error("unmatched quote outside the end item");

    // Byte 0 returns the scanner to its reset state.
    a_eot_resets_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_byte == CH_NUL) |=>
            (r_state.mode == MODE_BETWEEN && r_state.pair_byte == 8'h00))
        else $error("scan state not cleared after end of text");

    // A lexeme never starts with a blank.
    a_no_blank_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_begins_lexeme) |-> !is_blank(o_out_byte))
        else $error("lexeme starts with a blank");

endmodule

// File: sv/sls_lex_core.sv
// ----------------------------------------------------------------------------
// sls_lex_core: one-byte scan step
// Given the current scan state, the configuration and one text byte,
// produces the optional result and the next scan state.
// ----------------------------------------------------------------------------
module sls_lex_core (
    input  logic [7:0]          i_byte,
    input  logic [2:0]          i_delimiter_set,
    input  logic                i_two_char_tokens,
    input  sls_pkg::t_scan_state i_state,
    output sls_pkg::t_scan_state o_state,
    output sls_pkg::t_result     o_result
);
    import sls_pkg::*;

    logic        w_delim;
    logic        w_blank;
    logic        w_quote;
    t_scan_state w_start_state;
    t_result     w_start_result;
    t_scan_state w_base;
    logic [7:0]  w_close_quote;

    assign w_delim = is_delim(i_delimiter_set, i_byte);
    assign w_blank = is_blank(i_byte);
    assign w_quote = (i_byte == CH_SQUOTE) || (i_byte == CH_DQUOTE);
    assign w_close_quote = i_state.quote_dq ? CH_DQUOTE : CH_SQUOTE;

    // A failed operator pair clears the pending byte before a new lexeme starts.
    always_comb begin
        w_base = i_state;
        if (i_state.mode == MODE_PAIR) begin
            w_base.pair_byte = 8'h00;
        end
    end

    // Starting a lexeme from the between-lexemes position.
    always_comb begin
        w_start_state  = w_base;
        w_start_result = '{present: 1'b1, out_byte: i_byte, begins: 1'b1,
                           eot: 1'b0, unmatched: 1'b0};
        if (w_blank) begin
            w_start_result.present = 1'b0;
            w_start_state.mode     = MODE_BETWEEN;
        end else if (!w_delim) begin
            w_start_state.mode = MODE_WORD;
        end else if (w_quote) begin
            w_start_state.mode     = MODE_QUOTE;
            w_start_state.quote_dq = (i_byte == CH_DQUOTE);
            w_start_state.ctrl_q   = 1'b0;
        end else if (i_two_char_tokens && is_op_lead(i_byte)) begin
            w_start_state.mode      = MODE_PAIR;
            w_start_state.pair_byte = i_byte;
        end else begin
            w_start_state.mode = MODE_BETWEEN;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '{present: 1'b1, out_byte: i_byte, begins: 1'b0,
                     eot: 1'b0, unmatched: 1'b0};
        if (i_byte == CH_NUL) begin
            o_result = '{present: 1'b1, out_byte: 8'h00, begins: 1'b0, eot: 1'b1,
                         unmatched: (i_state.mode == MODE_QUOTE)};
            o_state  = SCAN_RESET;
        end else begin
            case (i_state.mode)
                MODE_WORD: begin
                    if (w_delim) begin
                        o_state  = w_start_state;
                        o_result = w_start_result;
                    end
                end
                MODE_QUOTE: begin
                    if ((i_byte == w_close_quote) && !i_state.ctrl_q) begin
                        o_state.mode   = MODE_BETWEEN;
                        o_state.ctrl_q = 1'b0;
                    end else begin
                        o_state.ctrl_q = (i_byte == CH_CTRL_Q);
                    end
                end
                MODE_PAIR: begin
                    if (is_operator(i_state.pair_byte, i_byte)) begin
                        o_state.mode      = MODE_BETWEEN;
                        o_state.pair_byte = 8'h00;
                    end else begin
                        o_state  = w_start_state;
                        o_result = w_start_result;
                    end
                end
                default: begin
                    o_state  = w_start_state;
                    o_result = w_start_result;
                end
            endcase
        end
    end

endmodule

// File: tb/lexeme_stream_checker.sv
// ----------------------------------------------------------------------------
// lexeme_stream_checker: predicts and checks the lexeme splitter's results
// Watches the text, result and register channels, keeps its own copy of the
// scan state and the registers, and compares every result with the oldest
// predicted lexeme byte.
// ----------------------------------------------------------------------------
module lexeme_stream_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [7:0]                      i_out_byte,
    input  logic                            i_begins_lexeme,
    input  logic                            i_end_of_text,
    input  logic                            i_unmatched_quote,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [sls_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sls_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import sls_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       eot;
        logic       unmatched;
    } t_lexeme_byte;

    // Character classes; \015 is carriage return.
    string cmd_chars   = ";`'\" \t\015\n";
    string sub_chars   = "!@#$%^&-=+`{}:;'\"\\|,.<>/";
    string comma_chars = ",";
    string bq_chars    = " \t\015\n'\"";
    string blank_chars = " \t\015\n";
    string lead_chars  = ">=<!/~";
    string pair_chars  = ">>>=<===!=/==~/~";

    t_lexeme_byte lexeme_q[$];

    t_scan_mode  scan_mode;
    logic        quote_is_dq;
    logic        after_ctrl_q;
    logic [7:0]  lead_byte;
    logic [2:0]  delim_sel;
    logic        pairs_on;
    int          mismatches;

    function automatic logic has_char(string s, logic [7:0] c);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic splits_on(logic [7:0] c);
        case (delim_sel)
            SET_COMMAND: return has_char(cmd_chars, c);
            SET_SUB:     return has_char(sub_chars, c);
            SET_COMMA:   return has_char(comma_chars, c);
            SET_BQ:      return has_char(bq_chars, c);
            default:     return has_char(blank_chars, c);
        endcase
    endfunction

    function automatic logic forms_pair(logic [7:0] a, logic [7:0] b);
        for (int i = 0; i + 1 < pair_chars.len(); i += 2) begin
            if (pair_chars[i] == a && pair_chars[i+1] == b) return 1'b1;
        end
        return 1'b0;
    endfunction

    // A byte met outside any lexeme: blanks vanish, anything else opens one.
    task automatic open_lexeme(input logic [7:0] c);
        if (has_char(blank_chars, c)) begin
            scan_mode = MODE_BETWEEN;
            return;
        end
        lexeme_q.push_back('{ch: c, first: 1'b1, eot: 1'b0, unmatched: 1'b0});
        if (!splits_on(c)) begin
            scan_mode = MODE_WORD;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            scan_mode    = MODE_QUOTE;
            quote_is_dq  = (c == CH_DQUOTE);
            after_ctrl_q = 1'b0;
        end else if (pairs_on && has_char(lead_chars, c)) begin
            scan_mode = MODE_PAIR;
            lead_byte = c;
        end else begin
            scan_mode = MODE_BETWEEN;
        end
    endtask

    task automatic split_text_byte(input logic [7:0] c);
        logic [7:0] closer;
        if (c == CH_NUL) begin
            lexeme_q.push_back('{ch: CH_NUL, first: 1'b0, eot: 1'b1,
                                 unmatched: (scan_mode == MODE_QUOTE)});
            scan_mode    = MODE_BETWEEN;
            quote_is_dq  = 1'b0;
            after_ctrl_q = 1'b0;
            lead_byte    = '0;
            return;
        end
        case (scan_mode)
            MODE_WORD: begin
                if (splits_on(c)) open_lexeme(c);
                else lexeme_q.push_back('{ch: c, first: 1'b0, eot: 1'b0, unmatched: 1'b0});
            end
            MODE_QUOTE: begin
                closer = quote_is_dq ? CH_DQUOTE : CH_SQUOTE;
                lexeme_q.push_back('{ch: c, first: 1'b0, eot: 1'b0, unmatched: 1'b0});
                if (c == closer && !after_ctrl_q) begin
                    scan_mode    = MODE_BETWEEN;
                    after_ctrl_q = 1'b0;
                end else begin
                    after_ctrl_q = (c == CH_CTRL_Q);
                end
            end
            MODE_PAIR: begin
                if (forms_pair(lead_byte, c)) begin
                    lexeme_q.push_back('{ch: c, first: 1'b0, eot: 1'b0, unmatched: 1'b0});
                    scan_mode = MODE_BETWEEN;
                    lead_byte = '0;
                end else begin
                    lead_byte = '0;
                    open_lexeme(c);
                end
            end
            default: open_lexeme(c);
        endcase
    endtask

    always @(posedge i_clk) begin
        t_lexeme_byte got;
        t_lexeme_byte want;
        if (!i_rst_n) begin
            lexeme_q.delete();
            scan_mode    = MODE_BETWEEN;
            quote_is_dq  = 1'b0;
            after_ctrl_q = 1'b0;
            lead_byte    = '0;
            delim_sel    = SET_COMMAND;
            pairs_on     = 1'b0;
            mismatches   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DELIMITER_SET:   delim_sel = i_cfg_data;
                    CFG_TWO_CHAR_TOKENS: pairs_on  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = '{ch: i_out_byte, first: i_begins_lexeme, eot: i_end_of_text,
                        unmatched: i_unmatched_quote};
                if (lexeme_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: result %h/%b/%b/%b with nothing expected",
                                 got.ch, got.first, got.eot, got.unmatched);
                end else begin
                    want = lexeme_q.pop_front();
                    if (got.ch !== want.ch || got.first !== want.first ||
                        got.eot !== want.eot || got.unmatched !== want.unmatched) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"checker: byte/begins/end/unmatched expected ",
                                      "%h/%b/%b/%b, got %h/%b/%b/%b"},
                                     want.ch, want.first, want.eot, want.unmatched,
                                     got.ch, got.first, got.eot, got.unmatched);
                    end
                end
            end
            if (i_in_valid && i_in_ready) split_text_byte(i_text_byte);
        end
        o_fail_count <= mismatches;
        o_pending    <= lexeme_q.size();
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the shell lexeme splitter
// Feeds texts under every delimiter set with operators on and off, idles both
// channels at random, stalls the result side for a long stretch, and lets a
// checker beside the block predict and compare every result.
// ----------------------------------------------------------------------------
module tb_top;
    import sls_pkg::*;

    // Selector values the package leaves unnamed: the blank set and the
    // highest unused code, which must behave like the blank set.
    localparam logic [2:0] SET_BLANK  = 3'd4;
    localparam logic [2:0] SET_TOP    = 3'd7;
    // Register index with no register behind it; a write there changes nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASES        = 10;
    localparam int RX_HOLD_LEN   = 300;
    // This margin covers bytes that are dropped.
    localparam int DRAIN_CYCLES  = 4;

    // Directed text under the sub set with operators enabled: leading blanks,
    // a word, a good operator pair, a failed pair, a quote with an escaped
    // quote after 0x11, a blank, then a double quote left open with the two
    // top bit patterns inside, so the end item flags an unmatched quote.
    localparam logic [7:0] DIRECTED_TEXT [18] = '{
        8'h20, 8'h09, 8'h61, 8'h62, 8'h3E, 8'h3D, 8'h21, 8'h78, 8'h27,
        8'h11, 8'h27, 8'h71, 8'h27, 8'h0D, 8'h22, 8'hFF, 8'h80, 8'h00
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [7:0]             i_text_byte;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [7:0]             o_out_byte;
    logic                   o_begins_lexeme;
    logic                   o_end_of_text;
    logic                   o_unmatched_quote;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int sent_items;
    int rx_hold_len;
    bit tx_burst;
    bit tx_steady;
    bit rx_burst;
    longint cycles;

    // Alphabets for random text; \015 is carriage return.
    string blank_txt = " \t\015\n";
    string delim_txt = ";`'\"!@#$%^&-=+{}:\\|,.<>/~";
    string pair_txt  = ">>>=<===!=/==~/~";
    string lead_txt  = ">=<!/~";

    shell_lexeme_splitter_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_text_byte       (i_text_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_byte        (o_out_byte),
        .o_begins_lexeme   (o_begins_lexeme),
        .o_end_of_text     (o_end_of_text),
        .o_unmatched_quote (o_unmatched_quote),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    lexeme_stream_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_text_byte       (i_text_byte),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_out_byte        (o_out_byte),
        .i_begins_lexeme   (o_begins_lexeme),
        .i_end_of_text     (o_end_of_text),
        .i_unmatched_quote (o_unmatched_quote),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_from(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Offers one byte from a falling edge and returns at the falling edge
    // after it was taken. Valid is left high so that a following byte with
    // no gap goes out back to back; anything else that follows lowers it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        gap = (tx_burst || tx_steady) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_text_byte = b;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        sent_items++;
    endtask

    // The sender pauses until every predicted result has come out, then
    // gives dropped bytes time to leave the pipe.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // A quoted lexeme with random content, sometimes holding an escaped
    // closing quote and sometimes never closed.
    task automatic send_quoted();
        logic [7:0] q;
        int n;
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        n = $urandom_range(0, 6);
        send_byte(q);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0: begin
                    send_byte(CH_CTRL_Q);
                    send_byte(q);
                end
                1: send_byte(pick_from(blank_txt));
                2: send_byte((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
                3: send_byte(8'($urandom_range(1, 255)));
                default: send_byte(8'($urandom_range(8'h61, 8'h7A)));
            endcase
        end
        if ($urandom_range(0, 99) < 85) send_byte(q);
    endtask

    // One text of random pieces, nearly always closed by a zero byte.
    task automatic send_text();
        int pieces;
        int r;
        pieces = $urandom_range(1, 12);
        repeat (pieces) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_byte(8'($urandom_range(8'h61, 8'h7A)));
            end else if (r < 42) begin
                send_byte(pick_from(blank_txt));
            end else if (r < 50) begin
                // A whole operator pair, aligned as in the table.
                r = 2 * $urandom_range(0, pair_txt.len() / 2 - 1);
                send_byte(pair_txt[r]);
                send_byte(pair_txt[r+1]);
            end else if (r < 58) begin
                send_byte(pick_from(lead_txt));
                send_byte($urandom_range(0, 1) ? pick_from(lead_txt)
                                               : 8'($urandom_range(1, 255)));
            end else if (r < 66) begin
                send_quoted();
            end else if (r < 78) begin
                send_byte(pick_from(delim_txt));
            end else if (r < 84) begin
                send_byte(CH_CTRL_Q);
            end else begin
                send_byte(8'($urandom_range(1, 255)));
            end
        end
        if ($urandom_range(0, 9) != 0) send_byte(CH_NUL);
    endtask

    // Result side: a random stall before each item, and now and then a long
    // hold that the stimulus asks for.
    initial begin
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold_len > 0) begin
                i_out_ready = 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
            end
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int target;
        logic [2:0] sel;
        logic pairs;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_text_byte = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        sent_items  = 0;
        rx_hold_len = 0;
        tx_burst    = 1'b0;
        tx_steady   = 1'b0;
        rx_burst    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed text with the sub set and operators on.
        write_reg(CFG_DELIMITER_SET, SET_SUB);
        write_reg(CFG_TWO_CHAR_TOKENS, CFG_DATA_W'(1'b1));
        foreach (DIRECTED_TEXT[i]) send_byte(DIRECTED_TEXT[i]);
        wait_drained();

        // A write to the spare index must leave both registers alone.
        write_reg(CFG_SPARE_INDEX, SET_COMMA);

        // Back pressure: the result side holds off while a long word streams
        // in without gaps, so the block fills up and stalls its input.
        write_reg(CFG_DELIMITER_SET, SET_BLANK);
        write_reg(CFG_TWO_CHAR_TOKENS, CFG_DATA_W'(1'b0));
        tx_steady   = 1'b1;
        rx_hold_len = RX_HOLD_LEN;
        repeat (40) send_byte(8'($urandom_range(8'h41, 8'h5A)));
        send_byte(CH_NUL);
        tx_steady = 1'b0;
        wait_drained();

        // Random phases: every selector once, including the unused top code,
        // then random ones; operators off and on both covered early.
        for (int p = 0; p < PHASES; p++) begin
            sel   = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
            pairs = (p < 2) ? 1'(p) : 1'($urandom_range(0, 1));
            if (p == 7) sel = SET_TOP;
            write_reg(CFG_DELIMITER_SET, sel);
            write_reg(CFG_TWO_CHAR_TOKENS, CFG_DATA_W'(pairs));
            target = sent_items + RANDOM_ITEMS / PHASES;
            while (sent_items < target) send_text();
            // Close any open text so the next phase starts from a clean state.
            send_byte(CH_NUL);
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
